// ===== src/mte_pkg.sv =====
// Shared types and constants for the multi-tap echo.
package mte_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int GAIN_W    = 32;
    localparam int DLY_W     = 13;
    localparam int TAP_W     = GAIN_W + DLY_W;
    localparam int TAP_REGS  = 6;
    localparam int TAP_SEL_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = TAP_W;
    localparam int ACC_W     = 64;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_FIRST = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LAST  = 4'd7;

    localparam logic [SAMPLE_W-1:0] Q31_MAX = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0] Q31_MIN = 32'h8000_0000;
    localparam logic [ACC_W-1:0]    Q63_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [ACC_W-1:0]    Q63_MIN = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0]    ROUND_HALF = 64'h0000_0000_4000_0000;
    localparam logic [TAP_W-1:0]    TAP0_RESET = 45'h0000_7fff_ffff;

    typedef logic [TAP_REGS-1:0][TAP_W-1:0] tap_arr_t;

    // control word fields driven by the sequencer into the datapath
    typedef struct packed {
        logic mem_clr;    // write zero at the clear pointer
        logic in_ready;   // take an input item
        logic ctx_clr;    // clear accumulator and tap counter
        logic mem_wr;     // write the sample at the write pointer
        logic q_load;     // delay quotient for the current tap
        logic rd_en;      // read the delayed sample
        logic mul_load;   // tap product
        logic acc_load;   // saturating accumulate, next tap
        logic omul_load;  // output gain product, advance write pointer
        logic out_load;   // load result register when free
        logic out_pass;   // result is the input sample itself
    } ctrl_t;

    // datapath flags the sequencer branches on
    typedef struct packed {
        logic clr_busy;
        logic item_valid;
        logic enabled;
        logic more_taps;
        logic out_busy;
    } status_t;

endpackage

// ===== src/mte_ram.sv =====
// Delay line storage: one write port, one registered read port.
module mte_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mte_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mte_pkg::SAMPLE_W-1:0] rd_data
);
    import mte_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mte_dpath.sv =====
// Echo datapath: pointers, tap address, multiply-accumulate, output scaling.
module mte_dpath #(
    parameter int DELAY_DEPTH = 8192,
    parameter int NUM_TAPS    = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mte_pkg::ctrl_t                    ctrl,
    output mte_pkg::status_t                  status,
    input  logic                              enable,
    input  logic signed [mte_pkg::GAIN_W-1:0] out_gain,
    input  mte_pkg::tap_arr_t                 taps,
    input  logic                              s_valid,
    input  logic signed [mte_pkg::SAMPLE_W-1:0] s_in_sample,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic signed [mte_pkg::SAMPLE_W-1:0] m_out_sample
);
    import mte_pkg::*;

    localparam int ADDR_W   = $clog2(DELAY_DEPTH);
    localparam int DW       = ADDR_W + 1;
    // floor(dly / DEPTH) = (dly * RECIP) >> RECIP_SH, exact for 13-bit delays
    localparam int RECIP_SH = DLY_W + ADDR_W;
    localparam int RECIP_W  = 16;
    localparam int RECIP    = (2**RECIP_SH + DELAY_DEPTH - 1) / DELAY_DEPTH;
    localparam int QP_W     = DLY_W + RECIP_W;
    localparam int MULW     = DLY_W + DW;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [MULW-1:0]    DEPTH_M = MULW'(DELAY_DEPTH);
    localparam logic [DW-1:0]      DEPTH_D = DW'(DELAY_DEPTH);
    localparam logic [ADDR_W-1:0]  LAST_A  = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic [TAP_SEL_W-1:0] LAST_TAP = TAP_SEL_W'(NUM_TAPS - 1);

    logic [ADDR_W-1:0]     clr_addr_reg, wpos_reg;
    logic [TAP_SEL_W-1:0]  tap_idx_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [DLY_W-1:0]      q_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_reg, omul_reg;
    logic                  minmin_reg;
    logic                  m_valid_reg;
    logic [SAMPLE_W-1:0]   m_data_reg;

    logic [TAP_W-1:0]      tap_cur;
    logic [DLY_W-1:0]      dly;
    logic signed [GAIN_W-1:0] gain;
    logic [QP_W-1:0]       qprod;
    logic [MULW-1:0]       qd, rem_raw;
    logic [DW-1:0]         rem, pos_ext, idx_w;
    logic [ADDR_W-1:0]     rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic signed [ACC_W-1:0] prod_full, term, omul_full, rnd;
    logic [ACC_W:0]        sum;
    logic [ACC_W-1:0]      acc_sat;
    logic [SAMPLE_W-1:0]   echo_out, out_data;
    logic                  out_fire;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [SAMPLE_W-1:0]   wr_data;

    assign tap_cur = taps[tap_idx_reg];
    assign dly     = tap_cur[TAP_W-1:GAIN_W];
    assign gain    = signed'(tap_cur[GAIN_W-1:0]);

    // delay reduced modulo the ring depth, then read address behind wpos
    assign qprod   = QP_W'(dly) * QP_W'(RECIP_C);
    assign qd      = MULW'(q_reg) * DEPTH_M;
    assign rem_raw = MULW'(dly) - qd;
    assign rem     = (rem_raw >= DEPTH_M) ? DW'(rem_raw - DEPTH_M) : DW'(rem_raw);
    assign pos_ext = DW'(wpos_reg);
    assign idx_w   = (pos_ext >= rem) ? (pos_ext - rem) : (pos_ext + DEPTH_D - rem);
    assign rd_addr = idx_w[ADDR_W-1:0];

    assign prod_full = rd_data * gain;
    assign term      = minmin_reg ? signed'(Q63_MAX) : (prod_reg <<< 1);
    assign sum       = {acc_reg[ACC_W-1], acc_reg} + {term[ACC_W-1], term};
    assign acc_sat   = (sum[ACC_W] != sum[ACC_W-1]) ? (sum[ACC_W] ? Q63_MIN : Q63_MAX)
                                                    : sum[ACC_W-1:0];

    assign omul_full = signed'(acc_reg[ACC_W-1:ACC_W-SAMPLE_W]) * out_gain;
    assign rnd       = omul_reg + signed'(ROUND_HALF);
    assign echo_out  = (rnd[ACC_W-1] != rnd[ACC_W-2]) ? (rnd[ACC_W-1] ? Q31_MIN : Q31_MAX)
                                                      : rnd[ACC_W-2:ACC_W-2-SAMPLE_W+1];
    assign out_data  = ctrl.out_pass ? sample_reg : echo_out;

    assign status.clr_busy   = (clr_addr_reg != LAST_A);
    assign status.item_valid = s_valid;
    assign status.enabled    = enable;
    assign status.more_taps  = (tap_idx_reg != LAST_TAP);
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign out_fire = ctrl.out_load && !(m_valid_reg && !m_ready);

    assign wr_en   = ctrl.mem_clr || ctrl.mem_wr;
    assign wr_addr = ctrl.mem_clr ? clr_addr_reg : wpos_reg;
    assign wr_data = ctrl.mem_clr ? '0 : sample_reg;

    mte_ram #(
        .DEPTH  (DELAY_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            wpos_reg     <= '0;
            tap_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (ctrl.mem_clr && (clr_addr_reg != LAST_A)) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (ctrl.omul_load) begin
                wpos_reg <= (wpos_reg == LAST_A) ? '0 : wpos_reg + 1'b1;
            end
            if (ctrl.ctx_clr) begin
                tap_idx_reg <= '0;
            end else if (ctrl.acc_load) begin
                tap_idx_reg <= tap_idx_reg + 1'b1;
            end
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.in_ready && s_valid) begin
            sample_reg <= s_in_sample;
        end
        if (ctrl.q_load) begin
            q_reg <= DLY_W'(qprod >> RECIP_SH);
        end
        if (ctrl.mul_load) begin
            prod_reg   <= prod_full;
            minmin_reg <= (rd_data == signed'(Q31_MIN)) && (gain == signed'(Q31_MIN));
        end
        if (ctrl.ctx_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_load) begin
            acc_reg <= signed'(acc_sat);
        end
        if (ctrl.omul_load) begin
            omul_reg <= omul_full;
        end
        if (out_fire) begin
            m_data_reg <= out_data;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = signed'(m_data_reg);

endmodule

// ===== src/mte_seq.sv =====
// Microcode sequencer: step counter, control ROM and branch logic.
module mte_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  mte_pkg::status_t status,
    output mte_pkg::ctrl_t   ctrl
);
    import mte_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_WRITE, ST_TAP_Q, ST_TAP_RD,
        ST_TAP_MUL, ST_TAP_ACC, ST_OUT_MUL, ST_OUT_DONE, ST_PASS
    } step_t;

    typedef enum logic [2:0] {
        C_NONE, C_CLR_BUSY, C_NO_ITEM, C_DISABLED, C_MORE_TAPS, C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t jump;  // taken when cond holds
        step_t next;  // otherwise
    } uword_t;

    function automatic uword_t ucode_rom(step_t s);
        uword_t uw;
        uw = '0;
        uw.cond = C_NONE;
        uw.jump = ST_IDLE;
        uw.next = ST_IDLE;
        case (s)
            ST_CLEAR: begin
                uw.ctrl.mem_clr = 1'b1;
                uw.cond = C_CLR_BUSY; uw.jump = ST_CLEAR; uw.next = ST_IDLE;
            end
            ST_IDLE: begin
                uw.ctrl.in_ready = 1'b1;
                uw.ctrl.ctx_clr  = 1'b1;
                uw.cond = C_NO_ITEM; uw.jump = ST_IDLE; uw.next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                uw.cond = C_DISABLED; uw.jump = ST_PASS; uw.next = ST_WRITE;
            end
            ST_WRITE: begin
                uw.ctrl.mem_wr = 1'b1;
                uw.next = ST_TAP_Q;
            end
            ST_TAP_Q: begin
                uw.ctrl.q_load = 1'b1;
                uw.next = ST_TAP_RD;
            end
            ST_TAP_RD: begin
                uw.ctrl.rd_en = 1'b1;
                uw.next = ST_TAP_MUL;
            end
            ST_TAP_MUL: begin
                uw.ctrl.mul_load = 1'b1;
                uw.next = ST_TAP_ACC;
            end
            ST_TAP_ACC: begin
                uw.ctrl.acc_load = 1'b1;
                uw.cond = C_MORE_TAPS; uw.jump = ST_TAP_Q; uw.next = ST_OUT_MUL;
            end
            ST_OUT_MUL: begin
                uw.ctrl.omul_load = 1'b1;
                uw.next = ST_OUT_DONE;
            end
            ST_OUT_DONE: begin
                uw.ctrl.out_load = 1'b1;
                uw.cond = C_OUT_BUSY; uw.jump = ST_OUT_DONE; uw.next = ST_IDLE;
            end
            ST_PASS: begin
                uw.ctrl.out_load = 1'b1;
                uw.ctrl.out_pass = 1'b1;
                uw.cond = C_OUT_BUSY; uw.jump = ST_PASS; uw.next = ST_IDLE;
            end
            default: begin
                uw.next = ST_IDLE;
            end
        endcase
        return uw;
    endfunction

    step_t  pc_reg, pc_next;
    uword_t uw;
    logic   taken;

    assign uw = ucode_rom(pc_reg);

    always_comb begin
        case (uw.cond)
            C_NONE:      taken = 1'b0;
            C_CLR_BUSY:  taken = status.clr_busy;
            C_NO_ITEM:   taken = !status.item_valid;
            C_DISABLED:  taken = !status.enabled;
            C_MORE_TAPS: taken = status.more_taps;
            C_OUT_BUSY:  taken = status.out_busy;
            default:     taken = 1'b0;
        endcase
        pc_next = taken ? uw.jump : uw.next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_CLEAR;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = uw.ctrl;

endmodule

// ===== src/multi_tap_echo.sv =====
// Top level of the multi-tap echo: configuration registers, sequencer and datapath.
//
// One channel of multi-tap echo on Q31 samples. Each enabled item is written
// into a ring of DELAY_DEPTH samples; NUM_TAPS taps (gain in bits 31:0, delay
// in bits 44:32 of each tap register, delay 0 = current item) are multiplied
// and summed into a saturating Q1.63 accumulator, whose high word is scaled by
// the output gain with round-half-up and saturation. A tap with zero gain adds
// nothing. With enable low the item passes straight through and the ring is
// untouched. Timing: a microcoded sequencer runs one step per cycle, and each
// tap takes four steps (delay reduction, ring read, multiply, accumulate) on
// the single ring read port and the tap multiplier, so items are taken one
// at a time: no new item is taken until the last item's result is loaded.
// After reset the ring is zeroed one entry per cycle, so s_ready stays low
// until the whole ring is clear; register writes are taken throughout.
// The result sits in an output register, so the next item is accepted while
// a result still waits for m_ready. Registers: 0 enable, 1 output gain,
// 2..7 tap_0..tap_5; other indexes are ignored. Write them only when idle.
module multi_tap_echo #(
    parameter int DELAY_DEPTH = 8192,
    parameter int NUM_TAPS    = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mte_pkg::SAMPLE_W-1:0] s_in_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mte_pkg::SAMPLE_W-1:0] m_out_sample
);
    import mte_pkg::*;

    logic                     enable_reg;
    logic signed [GAIN_W-1:0] out_gain_reg;
    tap_arr_t                 taps_reg;
    ctrl_t                    ctrl;
    status_t                  status;

    // configuration registers; tap index is offset from the first tap code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b1;
            out_gain_reg <= signed'(Q31_MAX);
            // tap_0 near unity at delay 0, the rest unused
            taps_reg     <= {{(TAP_REGS-1)*TAP_W{1'b0}}, TAP0_RESET};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLE:   enable_reg   <= cfg_wdata[0];
                CFG_OUT_GAIN: out_gain_reg <= signed'(cfg_wdata[GAIN_W-1:0]);
                default: begin
                    if (cfg_index inside {[CFG_TAP_FIRST:CFG_TAP_LAST]}) begin
                        taps_reg[TAP_SEL_W'(cfg_index - CFG_TAP_FIRST)] <= cfg_wdata;
                    end
                end
            endcase
        end
    end

    mte_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    mte_dpath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .NUM_TAPS    (NUM_TAPS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .status       (status),
        .enable       (enable_reg),
        .out_gain     (out_gain_reg),
        .taps         (taps_reg),
        .s_valid      (s_valid),
        .s_in_sample  (s_in_sample),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_sample (m_out_sample)
    );

    // input taken only at the idle step of the program
    assign s_ready = ctrl.in_ready;

endmodule

// ===== src/mte_checker.sv =====
// Port-level assertions for the multi-tap echo, bound to the top level.
module mte_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [mte_pkg::SAMPLE_W-1:0] m_out_sample
);

    // ring clear runs first, so no item is taken right out of reset
    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("s_ready high at the end of reset");

    // one item at a time: ready drops after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready held after an item was taken");

    // no result can appear in the cycle after reset
    a_no_result_from_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid straight after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_sample)))
        else $error("stalled result dropped or changed");

endmodule

bind multi_tap_echo mte_checker u_mte_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample)
);
